### design/sif_pkg.sv
// Shared types and constants of the segment intersection filter.
package sif_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned MaxSegments = 4096;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned IdxW        = 12;
  localparam int unsigned DiffW       = CoordW + 1;
  localparam int unsigned ProdW       = 2 * DiffW;
  localparam int unsigned SumW        = ProdW + 1;
  localparam int unsigned DivW        = SumW + 1;
  localparam int unsigned CfgIdxW     = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegStartX = 2'd0,
    RegStartY = 2'd1,
    RegGoalX  = 2'd2,
    RegGoalY  = 2'd3
  } cfg_reg_e;

endpackage

### design/sif_div.sv
// Pipelined restoring divider that yields a Q(FRAC_BITS) parameter and its unit range check.
module sif_div import sif_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                 clk_i,
  input  logic [DivW-1:0]      num_i,
  input  logic [DivW-1:0]      den_i,
  input  logic                 neg_i,
  output logic                 ok_o,
  output logic [FRAC_BITS:0]   val_o
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam logic [QW-1:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  logic [DivW-1:0] r_q   [FRAC_BITS+1];
  logic [DivW-1:0] d_q   [FRAC_BITS+1];
  logic [QW-1:0]   q_q   [FRAC_BITS+1];
  logic            neg_q [FRAC_BITS+1];
  logic            over_q[FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    over_q[0] <= num_i >= {den_i[DivW-2:0], 1'b0};
    neg_q[0]  <= neg_i;
    d_q[0]    <= den_i;
    if (num_i >= den_i) begin
      r_q[0] <= num_i - den_i;
      q_q[0] <= QW'(1);
    end else begin
      r_q[0] <= num_i;
      q_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [DivW-1:0] rs;
    logic            ge;
    always_comb begin
      rs = {r_q[k-1][DivW-2:0], 1'b0};
      ge = rs >= d_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      r_q[k]    <= ge ? (rs - d_q[k-1]) : rs;
      q_q[k]    <= {q_q[k-1][QW-2:0], ge};
      d_q[k]    <= d_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      over_q[k] <= over_q[k-1];
    end
  end

  assign val_o = q_q[FRAC_BITS];
  assign ok_o  = (q_q[FRAC_BITS] == '0) ||
                 (!over_q[FRAC_BITS] && !neg_q[FRAC_BITS] && (q_q[FRAC_BITS] <= One));

endmodule

### design/segment_intersection_filter_top.sv
// Top level of the segment intersection filter: config registers and datapath pipeline.
//
// Usage:
//   Write the query start and goal through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while no item is in flight. Each write lands at the clock edge where
//   cfg_we_i is high.
//   Issue one obstacle segment per cycle with start_i; it is taken when busy_o
//   is low, and busy_o is always low, so one item enters every cycle.
//   A crossing segment shows up on hit_index_o, cross_x_o and cross_y_o for
//   one cycle with valid_o high, after the difference, product, sum,
//   magnitude, divider, parameter check, offset multiply and final add stages.
//   Segments that miss, are parallel, hit the start exactly or carry an index
//   at or above MaxSegments give nothing. The divider resolves one quotient
//   bit per stage over FRAC_BITS + 1 stages; throughput is one item per cycle.
//   Reset clears all valid bits and the four query registers to zero.
//   The receiver cannot stall; results are presented once and not held.
module segment_intersection_filter_top import sif_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [CoordW-1:0]  first_x_i,
  input  logic [CoordW-1:0]  first_y_i,
  input  logic [CoordW-1:0]  second_x_i,
  input  logic [CoordW-1:0]  second_y_i,
  input  logic [IdxW-1:0]    segment_index_i,
  output logic               valid_o,
  output logic [IdxW-1:0]    hit_index_o,
  output logic [CoordW-1:0]  cross_x_o,
  output logic [CoordW-1:0]  cross_y_o
);

  localparam int unsigned DivLat = FRAC_BITS + 1;
  localparam int unsigned TW     = FRAC_BITS + 1;
  localparam int unsigned MulW   = TW + 1 + DiffW;
  localparam int unsigned LimW   = 17;

  logic signed [CoordW-1:0] start_x_q, start_y_q, goal_x_q, goal_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      goal_x_q  <= '0;
      goal_y_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegStartX: start_x_q <= cfg_wdata_i;
        RegStartY: start_y_q <= cfg_wdata_i;
        RegGoalX:  goal_x_q  <= cfg_wdata_i;
        RegGoalY:  goal_y_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic signed [DiffW-1:0] d1x, d1y;
  assign d1x = DiffW'(goal_x_q) - DiffW'(start_x_q);
  assign d1y = DiffW'(goal_y_q) - DiffW'(start_y_q);

  // Stage 1: differences
  logic                    v1_q;
  logic signed [DiffW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, ox_q, oy_q;
  logic [IdxW-1:0]         idx1_q;
  logic                    in_ok;
  assign in_ok = start_i && !busy_o && (LimW'(segment_index_i) < LimW'(MaxSegments));

  // Stage 2: products
  logic                    v2_q;
  logic signed [ProdW-1:0] p_a_q, p_b_q, p_c_q, p_d_q, p_e_q, p_f_q;
  logic [IdxW-1:0]         idx2_q;

  // Stage 3: sums
  logic                    v3_q;
  logic signed [SumW-1:0]  den_q, ns_q, nt_q;
  logic [IdxW-1:0]         idx3_q;

  // Stage 4: magnitudes
  logic                    v4_q;
  logic [DivW-1:0]         nsa_q, nta_q, dena_q;
  logic                    negs_q, negt_q;
  logic [IdxW-1:0]         idx4_q;

  logic [DivW-1:0]         nsa_d, nta_d, dena_d;
  assign nsa_d  = ns_q[SumW-1]  ? DivW'(-DivW'(ns_q))  : DivW'(ns_q);
  assign nta_d  = nt_q[SumW-1]  ? DivW'(-DivW'(nt_q))  : DivW'(nt_q);
  assign dena_d = den_q[SumW-1] ? DivW'(-DivW'(den_q)) : DivW'(den_q);

  // Divider stages
  logic                    vdiv_q  [DivLat];
  logic [IdxW-1:0]         idxdiv_q[DivLat];
  logic                    ok_s, ok_t;
  logic [TW-1:0]           val_s, val_t;

  sif_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
    .clk_i (clk_i),
    .num_i (nsa_q),
    .den_i (dena_q),
    .neg_i (negs_q),
    .ok_o  (ok_s),
    .val_o (val_s)
  );

  sif_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
    .clk_i (clk_i),
    .num_i (nta_q),
    .den_i (dena_q),
    .neg_i (negt_q),
    .ok_o  (ok_t),
    .val_o (val_t)
  );

  // Parameter check, offset multiply, final add
  logic                    va_q, vm_q;
  logic [TW-1:0]           t_q;
  logic [IdxW-1:0]         idxa_q, idxm_q;
  logic signed [MulW-1:0]  px_q, py_q;

  logic signed [MulW-1:0]  offx, offy;
  logic signed [MulW-1:0]  round_bias;
  assign round_bias = MulW'((1 << FRAC_BITS) - 1);
  assign offx = (px_q[MulW-1] ? (px_q + round_bias) : px_q) >>> FRAC_BITS;
  assign offy = (py_q[MulW-1] ? (py_q + round_bias) : py_q) >>> FRAC_BITS;

  logic                    out_v_q;
  logic [IdxW-1:0]         hit_q;
  logic [CoordW-1:0]       cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      for (int i = 0; i < DivLat; i++) vdiv_q[i] <= 1'b0;
      va_q    <= 1'b0;
      vm_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v1_q <= in_ok;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q && (den_q != '0);
      vdiv_q[0] <= v4_q;
      for (int i = 1; i < DivLat; i++) vdiv_q[i] <= vdiv_q[i-1];
      va_q    <= vdiv_q[DivLat-1] && ok_s && ok_t;
      vm_q    <= va_q;
      out_v_q <= vm_q && ((offx != '0) || (offy != '0));
    end
  end

  always_ff @(posedge clk_i) begin
    d1x_q  <= d1x;
    d1y_q  <= d1y;
    d2x_q  <= DiffW'($signed(second_x_i)) - DiffW'($signed(first_x_i));
    d2y_q  <= DiffW'($signed(second_y_i)) - DiffW'($signed(first_y_i));
    ox_q   <= DiffW'(start_x_q) - DiffW'($signed(first_x_i));
    oy_q   <= DiffW'(start_y_q) - DiffW'($signed(first_y_i));
    idx1_q <= segment_index_i;

    p_a_q  <= ProdW'(d1x_q) * ProdW'(d2y_q);
    p_b_q  <= ProdW'(d2x_q) * ProdW'(d1y_q);
    p_c_q  <= ProdW'(d1x_q) * ProdW'(oy_q);
    p_d_q  <= ProdW'(d1y_q) * ProdW'(ox_q);
    p_e_q  <= ProdW'(d2x_q) * ProdW'(oy_q);
    p_f_q  <= ProdW'(d2y_q) * ProdW'(ox_q);
    idx2_q <= idx1_q;

    den_q  <= SumW'(p_a_q) - SumW'(p_b_q);
    ns_q   <= SumW'(p_c_q) - SumW'(p_d_q);
    nt_q   <= SumW'(p_e_q) - SumW'(p_f_q);
    idx3_q <= idx2_q;

    nsa_q  <= nsa_d;
    nta_q  <= nta_d;
    dena_q <= dena_d;
    negs_q <= ns_q[SumW-1] ^ den_q[SumW-1];
    negt_q <= nt_q[SumW-1] ^ den_q[SumW-1];
    idx4_q <= idx3_q;

    idxdiv_q[0] <= idx4_q;
    for (int i = 1; i < DivLat; i++) idxdiv_q[i] <= idxdiv_q[i-1];

    t_q    <= val_t;
    idxa_q <= idxdiv_q[DivLat-1];

    px_q   <= MulW'($signed({1'b0, t_q})) * MulW'(d1x);
    py_q   <= MulW'($signed({1'b0, t_q})) * MulW'(d1y);
    idxm_q <= idxa_q;

    hit_q  <= idxm_q;
    cx_q   <= CoordW'(MulW'(start_x_q) + offx);
    cy_q   <= CoordW'(MulW'(start_y_q) + offy);
  end

  assign valid_o     = out_v_q;
  assign hit_index_o = hit_q;
  assign cross_x_o   = cx_q;
  assign cross_y_o   = cy_q;

  logic signed [CoordW-1:0] cxs, cys;
  assign cxs = cross_x_o;
  assign cys = cross_y_o;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (LimW'(hit_index_o) < LimW'(MaxSegments)))
    else $error("result index out of range");

  a_param_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vdiv_q[DivLat-1] && ok_s) |-> (val_s <= TW'(1 << FRAC_BITS)))
    else $error("accepted parameter above one");

  a_cross_x_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((cxs >= start_x_q && cxs <= goal_x_q) ||
                 (cxs <= start_x_q && cxs >= goal_x_q)))
    else $error("cross_x outside query segment");

  a_cross_y_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((cys >= start_y_q && cys <= goal_y_q) ||
                 (cys <= start_y_q && cys >= goal_y_q)))
    else $error("cross_y outside query segment");

endmodule

### bench/segment_intersection_filter_top_tb.sv
// Testbench for the segment intersection filter: directed and random obstacle segments.
`timescale 1ns / 1ps

module segment_intersection_filter_top_tb;
  import sif_pkg::*;

  localparam int unsigned FracBits = FracBitsDef;
  localparam longint One = longint'(1) << FracBits;
  localparam int unsigned DrainCycles = FracBits + 16;

  typedef struct packed {
    logic [IdxW-1:0]   index;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } crossing_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegStartX;
  logic [CoordW-1:0] cfg_wdata_i = '0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [CoordW-1:0] first_x_i = '0;
  logic [CoordW-1:0] first_y_i = '0;
  logic [CoordW-1:0] second_x_i = '0;
  logic [CoordW-1:0] second_y_i = '0;
  logic [IdxW-1:0]   segment_index_i = '0;
  logic              valid_o;
  logic [IdxW-1:0]   hit_index_o;
  logic [CoordW-1:0] cross_x_o;
  logic [CoordW-1:0] cross_y_o;

  segment_intersection_filter_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [CoordW-1:0] query_sx = '0, query_sy = '0, query_gx = '0, query_gy = '0;
  crossing_t expected_hits[$];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned hits_seen = 0;
  int unsigned idle_pct = 0;

  // Truncated Q(FracBits) quotient, accepted only if it lies in [0,1].
  function automatic bit unit_param(input logic signed [127:0] num,
                                    input logic signed [127:0] den, output longint val);
    logic [127:0] n, d, q;
    bit neg;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    q = (n << FracBits) / d;
    val = 0;
    if (q == 0) return 1'b1;
    if (neg || q > One) return 1'b0;
    val = longint'(q);
    return 1'b1;
  endfunction

  function automatic bit predict_crossing(input logic signed [CoordW-1:0] fx, fy, sx, sy,
                                          input logic [IdxW-1:0] idx, output crossing_t hit);
    logic signed [127:0] d1x, d1y, d2x, d2y, ox, oy, den, ns, nt;
    longint s, t, offx, offy;
    d1x = 128'(query_gx) - 128'(query_sx);
    d1y = 128'(query_gy) - 128'(query_sy);
    d2x = 128'(sx) - 128'(fx);
    d2y = 128'(sy) - 128'(fy);
    ox = 128'(query_sx) - 128'(fx);
    oy = 128'(query_sy) - 128'(fy);
    hit = '0;
    den = d1x * d2y - d2x * d1y;
    if (den == 0) return 1'b0;
    ns = d1x * oy - d1y * ox;
    nt = d2x * oy - d2y * ox;
    if (!unit_param(ns, den, s)) return 1'b0;
    if (!unit_param(nt, den, t)) return 1'b0;
    offx = (t * longint'(d1x)) / One;
    offy = (t * longint'(d1y)) / One;
    if (offx == 0 && offy == 0) return 1'b0;
    hit.index = idx;
    hit.x = CoordW'(longint'(query_sx) + offx);
    hit.y = CoordW'(longint'(query_sy) + offy);
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    crossing_t hit, exp_hit;
    if (start_i && !busy_o) begin
      if (predict_crossing(first_x_i, first_y_i, second_x_i, second_y_i, segment_index_i, hit))
        expected_hits.insert(expected_hits.size(), hit);
    end
    if (valid_o) begin
      hits_seen++;
      if (expected_hits.size() == 0) begin
        $error("unexpected result: index %0d x %h y %h", hit_index_o, cross_x_o, cross_y_o);
        err_count++;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (hit_index_o !== exp_hit.index) begin
          $error("hit_index: expected %0d, got %0d", exp_hit.index, hit_index_o);
          err_count++;
        end
        if (cross_x_o !== exp_hit.x) begin
          $error("cross_x: expected %h, got %h", exp_hit.x, cross_x_o);
          err_count++;
        end
        if (cross_y_o !== exp_hit.y) begin
          $error("cross_y: expected %h, got %h", exp_hit.y, cross_y_o);
          err_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [CoordW-1:0] fx, fy, sx, sy,
                           input logic [IdxW-1:0] idx);
    start_i <= 1'b1;
    first_x_i <= fx;
    first_y_i <= fy;
    second_x_i <= sx;
    second_y_i <= sy;
    segment_index_i <= idx;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_query(input logic [CoordW-1:0] sx, sy, gx, gy);
    logic [CoordW-1:0] vals[4];
    vals = '{sx, sy, gx, gy};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    query_sx = sx;
    query_sy = sy;
    query_gx = gx;
    query_gy = gy;
  endtask

  // Segment through a point of the query line, so most of these cross.
  task automatic send_crossing(input int unsigned span);
    longint px, py, vx, vy, k;
    longint t;
    t = $urandom_range(One);
    px = longint'(query_sx) + (t * (longint'(query_gx) - longint'(query_sx))) / One;
    py = longint'(query_sy) + (t * (longint'(query_gy) - longint'(query_sy))) / One;
    vx = longint'($urandom_range(2 * span)) - span;
    vy = longint'($urandom_range(2 * span)) - span;
    k = $urandom_range(3, 0);
    send_item(CoordW'(px + vx), CoordW'(py + vy), CoordW'(px - k * vx), CoordW'(py - k * vy),
              IdxW'($urandom));
  endtask

  task automatic test_zero_query();
    send_item(32'h0001_0000, 32'hffff_0000, 32'hffff_0000, 32'h0001_0000, 12'd5);
    send_item($urandom, $urandom, $urandom, $urandom, 12'hfff);
  endtask

  task automatic test_directed();
    write_query(32'h0000_0000, 32'h0000_0000, 32'h000a_0000, 32'h0000_0000);
    send_item(32'h0005_0000, 32'hfffb_0000, 32'h0005_0000, 32'h0005_0000, 12'd0);
    send_item(32'h0005_0000, 32'hfffb_0000, 32'h0005_0000, 32'h0005_0000, 12'hfff);
    send_item(32'h0002_0000, 32'h0001_0000, 32'h0008_0000, 32'h0001_0000, 12'd1);
    send_item(32'h0003_0000, 32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 12'd2);
    send_item(32'h0000_0000, 32'hffff_0000, 32'h0000_0000, 32'h0001_0000, 12'd3);
    send_item(32'hffff_ffff, 32'hffff_0000, 32'hffff_ffff, 32'h0001_0000, 12'd4);
    send_item(32'h000a_0000, 32'hffff_0000, 32'h000a_0000, 32'h0001_0000, 12'd6);
    send_item(32'h000a_0001, 32'hffff_0000, 32'h000a_0001, 32'h0001_0000, 12'd7);
    send_item(32'h0005_0000, 32'h0000_0001, 32'h0005_0000, 32'h0005_0000, 12'd8);
    send_item(32'h0004_0000, 32'hffff_0000, 32'h0006_0000, 32'h0001_0000, 12'd9);
    send_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 12'd10);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 12'd11);
    write_query(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 12'd12);
    send_item(32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 12'd13);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 12'd14);
    send_item(32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 12'd15);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 12'd16);
  endtask

  task automatic test_random_phase(input int unsigned count, input int unsigned span);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) send_crossing(span);
      else send_item($urandom, $urandom, $urandom, $urandom, IdxW'($urandom));
    end
  endtask

  task automatic test_random();
    int unsigned pcts[3];
    pcts = '{27, 48, 0};
    for (int p = 0; p < 3; p++) begin
      idle_pct = pcts[p];
      write_query($urandom_range(32'h00ff_ffff), $urandom_range(32'h00ff_ffff),
                  $urandom, $urandom);
      test_random_phase(250, 32'h0100_0000);
      write_query(32'h0001_0000, 32'hfff0_0000, 32'h0003_0000, 32'h0010_0000);
      test_random_phase(150, 32'h0004_0000);
      write_query(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      test_random_phase(100, 32'h4000_0000);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_query();
    test_directed();
    test_random();
    settle();
    $display("covered %0d segments, %0d crossings reported, several query settings",
             items_sent, hits_seen);
    if (err_count == 0 && expected_hits.size() == 0) begin
      $display("segment_intersection_filter_top_tb: done, clean");
    end else begin
      if (expected_hits.size() != 0) $error("%0d results missing", expected_hits.size());
      $display("segment_intersection_filter_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("segment_intersection_filter_top_tb: done, errors");
    $finish;
  end

endmodule
